// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the edge-to-KISS framer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ETKF_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("etkf check failed");

// Consequent must hold in the same cycle as the antecedent.
`define ETKF_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etkf implication failed");

`endif

// ----- rtl/etkf_pkg.sv -----
// Package for the edge-to-KISS framer: payload structs, command type,
// framing constants and byte-escape helpers. No dependencies.
package etkf_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int GAP_BITS        = 32;

  // Quotient width: enough to hold run lengths up to 2*GAP_BITS-1.
  localparam int CNT_W  = $clog2(GAP_BITS + 1);
  localparam int FRAME_W = 16;
  localparam logic [FRAME_W-1:0] FRAME_BIT_LIMIT = FRAME_W'(MAX_FRAME_BYTES * 8);

  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [31:0] BIT_PERIOD_RESET = 32'(80 * 1000 * 1000 / 1200);

  localparam logic [7:0] KISS_FEND  = 8'hc0;
  localparam logic [7:0] KISS_FESC  = 8'hdb;
  localparam logic [7:0] KISS_TFEND = 8'hdc;
  localparam logic [7:0] KISS_TFESC = 8'hdd;

  typedef struct packed {
    logic        mode;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic {
    CMD_BITS  = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             level;
    logic [CNT_W-1:0] count;
  } cmd_t;

  function automatic logic is_special(input logic [7:0] b);
    return (b == KISS_FEND) || (b == KISS_FESC);
  endfunction

  function automatic logic [7:0] esc_first(input logic [7:0] b);
    return is_special(b) ? KISS_FESC : b;
  endfunction

  function automatic logic [7:0] esc_second(input logic [7:0] b);
    return (b == KISS_FEND) ? KISS_TFEND : KISS_TFESC;
  endfunction

endpackage

// ----- rtl/etkf_front.sv -----
// Front end: accepts items, holds bit_period and last_time, turns each edge
// into a run length with a bit-serial divider and queues a command.
// Depends on etkf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module etkf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  etkf_pkg::in_item_t item,
  output logic              cmd_push,
  output etkf_pkg::cmd_t    cmd,
  input  logic              cmd_full
);

  localparam int QW     = etkf_pkg::CNT_W;
  localparam int DW     = 32 + QW;
  localparam int STEP_W = $clog2(QW + 1);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_SUB  = 6'b000010,
    F_CHK  = 6'b000100,
    F_DIV  = 6'b001000,
    F_RES  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t            state;
  logic [31:0]        bit_period;
  logic [31:0]        last_time;
  logic [31:0]        ts;
  logic [31:0]        per;
  logic [31:0]        rem;
  logic [DW-1:0]      d;
  logic [QW-1:0]      q;
  logic [STEP_W-1:0]  step;
  logic               ge;
  logic [DW:0]        rem_ext;
  logic [DW:0]        d_dbl;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == F_IDLE);
  assign cmd_push   = (state == F_PUSH) && !cmd_full;

  assign ge      = (DW'(rem) >= d);
  assign rem_ext = (DW + 1)'(rem);
  assign d_dbl   = {d, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      bit_period <= etkf_pkg::BIT_PERIOD_RESET;
      last_time  <= '0;
    end else begin
      if (cfg_valid) begin
        bit_period <= cfg_data;
      end
      unique case (state)
        F_IDLE: begin
          if (item_valid) begin
            ts  <= item.timestamp;
            per <= (bit_period == '0) ? 32'd1 : bit_period;
            if (item.mode) begin
              cmd.kind  <= etkf_pkg::CMD_CLOSE;
              cmd.level <= 1'b0;
              cmd.count <= '0;
              state     <= F_PUSH;
            end else begin
              state <= F_SUB;
            end
          end
        end
        F_SUB: begin
          rem   <= ts - last_time + (per >> 1);
          state <= F_CHK;
        end
        F_CHK: begin
          // Run of 2^QW bits or more is a gap for sure; skip the divide.
          if (DW'(rem) >= (DW'(per) << QW)) begin
            last_time <= ts;
            cmd.kind  <= etkf_pkg::CMD_CLOSE;
            cmd.level <= 1'b0;
            cmd.count <= '0;
            state     <= F_PUSH;
          end else begin
            d     <= DW'(per) << (QW - 1);
            q     <= '0;
            step  <= STEP_W'(QW - 1);
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (ge) begin
            rem <= rem - d[31:0];
          end
          q    <= {q[QW-2:0], ge};
          d    <= d >> 1;
          step <= step - 1'b1;
          if (step == '0) begin
            state <= F_RES;
          end
        end
        F_RES: begin
          if (q == '0) begin
            state <= F_IDLE;
          end else begin
            last_time <= ts;
            state     <= F_PUSH;
            if (32'(q) > 32'(etkf_pkg::GAP_BITS)) begin
              cmd.kind  <= etkf_pkg::CMD_CLOSE;
              cmd.level <= 1'b0;
              cmd.count <= '0;
            end else begin
              cmd.kind  <= etkf_pkg::CMD_BITS;
              cmd.level <= ts[0];
              cmd.count <= q;
            end
          end
        end
        F_PUSH: begin
          if (!cmd_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Restoring divide stays in range: remainder below twice the shifted divisor.
  `ETKF_IMPLIES(a_div_bound, state == F_DIV, rem_ext < d_dbl)

endmodule

// ----- rtl/etkf_cmd_fifo.sv -----
// Short command queue between the front end and the framer back end.
// Depends on etkf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module etkf_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  etkf_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output etkf_pkg::cmd_t pop_data
);

  localparam int DEPTH = etkf_pkg::CMD_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  etkf_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ETKF_IMPLIES(a_no_overflow, push, !full || pop)
  `ETKF_IMPLIES(a_no_underflow, pop, valid)

endmodule

// ----- rtl/etkf_back.sv -----
// Back end: executes queued commands, packs bits LSB first, applies KISS
// escaping and framing, and drives the result channel through a hold stage.
// Depends on etkf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module etkf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  etkf_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output etkf_pkg::out_item_t result
);

  localparam int QW = etkf_pkg::CNT_W;
  localparam int FW = etkf_pkg::FRAME_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BIT  = 6'b000010,
    S_PAD  = 6'b000100,
    S_ESC2 = 6'b001000,
    S_FEND = 6'b010000,
    S_DONE = 6'b100000
  } bstate_t;

  bstate_t       state, state_next;
  logic [QW-1:0] cnt, cnt_next;
  logic          level, level_next;
  logic [FW-1:0] frame_bits, frame_bits_next;
  logic [7:0]    pending_byte, pending_byte_next;
  logic [7:0]    esc2, esc2_next;
  logic          fend_after, fend_after_next;
  logic          hold_valid;
  logic [7:0]    hold_byte;

  logic          emit;
  logic [7:0]    emit_byte;
  logic          done;
  logic          pop;
  logic [FW-1:0] new_bits;
  logic [7:0]    new_byte;
  logic          need_push;
  logic          go;

  always_comb begin
    emit              = 1'b0;
    emit_byte         = '0;
    done              = 1'b0;
    pop               = 1'b0;
    state_next        = state;
    cnt_next          = cnt;
    level_next        = level;
    frame_bits_next   = frame_bits;
    pending_byte_next = pending_byte;
    esc2_next         = esc2;
    fend_after_next   = fend_after;
    new_bits          = frame_bits + 1'b1;
    new_byte          = pending_byte | ({7'b0, level} << frame_bits[2:0]);
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          if (cmd.kind == etkf_pkg::CMD_BITS) begin
            cnt_next   = cmd.count;
            level_next = cmd.level;
            state_next = S_BIT;
          end else begin
            cnt_next = '0;
            priority if (frame_bits == '0) begin
              state_next = S_DONE;
            end else if (frame_bits[2:0] != 3'd0) begin
              state_next = S_PAD;
            end else begin
              state_next = S_FEND;
            end
          end
        end
      end
      S_BIT: begin
        cnt_next          = cnt - 1'b1;
        frame_bits_next   = new_bits;
        pending_byte_next = new_byte;
        priority if (frame_bits == '0) begin
          // first bit of a frame: opening FEND
          emit       = 1'b1;
          emit_byte  = etkf_pkg::KISS_FEND;
          state_next = (cnt_next == '0) ? S_DONE : S_BIT;
        end else if (new_bits[2:0] == 3'd0) begin
          pending_byte_next = '0;
          emit              = 1'b1;
          emit_byte         = etkf_pkg::esc_first(new_byte);
          if (etkf_pkg::is_special(new_byte)) begin
            esc2_next       = etkf_pkg::esc_second(new_byte);
            fend_after_next = (new_bits == etkf_pkg::FRAME_BIT_LIMIT);
            state_next      = S_ESC2;
          end else if (new_bits == etkf_pkg::FRAME_BIT_LIMIT) begin
            state_next = S_FEND;
          end else begin
            state_next = (cnt_next == '0) ? S_DONE : S_BIT;
          end
        end else begin
          state_next = (cnt_next == '0) ? S_DONE : S_BIT;
        end
      end
      S_PAD: begin
        emit      = 1'b1;
        emit_byte = etkf_pkg::esc_first(pending_byte);
        if (etkf_pkg::is_special(pending_byte)) begin
          esc2_next       = etkf_pkg::esc_second(pending_byte);
          fend_after_next = 1'b1;
          state_next      = S_ESC2;
        end else begin
          state_next = S_FEND;
        end
      end
      S_ESC2: begin
        emit      = 1'b1;
        emit_byte = esc2;
        if (fend_after) begin
          state_next = S_FEND;
        end else begin
          state_next = (cnt == '0) ? S_DONE : S_BIT;
        end
      end
      S_FEND: begin
        emit              = 1'b1;
        emit_byte         = etkf_pkg::KISS_FEND;
        frame_bits_next   = '0;
        pending_byte_next = '0;
        state_next        = (cnt == '0) ? S_DONE : S_BIT;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // A held byte moves to the output when the next byte arrives (last = 0)
  // or when the command ends (last = 1).
  assign need_push = hold_valid && (emit || done);
  assign go        = !need_push || !result_valid || result_ready;
  assign cmd_pop   = pop && go;

  always_ff @(posedge clk) begin
    if (go) begin
      esc2 <= esc2_next;
      cnt  <= cnt_next;
      level <= level_next;
      if (emit) begin
        hold_byte <= emit_byte;
      end
      if (need_push) begin
        result.out_byte <= hold_byte;
        result.last     <= done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_bits   <= '0;
      pending_byte <= '0;
      fend_after   <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (go) begin
        state        <= state_next;
        frame_bits   <= frame_bits_next;
        pending_byte <= pending_byte_next;
        fend_after   <= fend_after_next;
        if (emit) begin
          hold_valid <= 1'b1;
        end else if (done) begin
          hold_valid <= 1'b0;
        end
      end
      priority if (go && need_push) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end else begin
        result_valid <= result_valid;
      end
    end
  end

  `ETKF_CHECK(a_frame_limit, frame_bits <= etkf_pkg::FRAME_BIT_LIMIT)
  `ETKF_IMPLIES(a_pad_partial, state == S_PAD, frame_bits[2:0] != 3'd0)
  `ETKF_IMPLIES(a_esc2_code, state == S_ESC2,
                esc2 == etkf_pkg::KISS_TFEND || esc2 == etkf_pkg::KISS_TFESC)

endmodule

// ----- rtl/edge_time_to_kiss_frames_top.sv -----
// Edge timestamps to KISS frames. For each edge the front end subtracts, compares against
// the gap bound, runs 6 divide steps, checks the quotient and pushes a command; a zero run
// pushes nothing, a run of 64 bits or more skips the divide, end of stream goes straight to
// the push. The back end takes the bits of a run one at a time, with extra states for padded
// bytes, escape pairs and closing FENDs, and stalls while the output is held. Synchronous
// active-high reset clears both ends, queue and output stage; bit_period returns to 66666.

module edge_time_to_kiss_frames_top (
  input  logic                clk,
  input  logic                rst,
  // bit_period register write transfer
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  // input item transfer: mode and timestamp
  input  logic                item_valid,
  output logic                item_ready,
  input  etkf_pkg::in_item_t  item,
  // result transfer: one framed byte and its last flag
  output logic                result_valid,
  input  logic                result_ready,
  output etkf_pkg::out_item_t result
);

  // Command queue links the divider front end to the framing back end,
  // so edges keep coming in while bytes wait at the output.
  logic           cmd_push;
  etkf_pkg::cmd_t cmd_in;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_valid;
  etkf_pkg::cmd_t cmd_out;

  etkf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full)
  );

  etkf_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .pop_data  (cmd_out)
  );

  // Back end owns frame state (bit count, partial byte) and the output stage.
  etkf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd_out),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for edge_time_to_kiss_frames_top: drives edge and flush items plus
// bit_period writes, and checks every framed output byte against a predictor.
// Depends on etkf_pkg and the RTL top; self-checking, no external files.
module tb_top;

  // Input item modes.
  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam int          HALF_PERIOD  = 10;
  localparam int          RESET_CYCLES = 12;
  // Settle time after a drain and receiver hold-off length; leave plenty of slack.
  localparam int          SETTLE_CYCLES = 200;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Framer predictor plus queue of expected output bytes.
  class kiss_scoreboard;
    logic [31:0]         bit_period;
    logic [31:0]         last_edge;
    logic [15:0]         frame_bits;
    logic [7:0]          partial;
    etkf_pkg::out_item_t expected_q[$];
    etkf_pkg::out_item_t item_bytes[$];
    int                  errors;

    function new();
      errors     = 0;
      bit_period = etkf_pkg::BIT_PERIOD_RESET;
      last_edge  = '0;
      frame_bits = '0;
      partial    = '0;
    endfunction

    function void set_period(logic [31:0] value);
      bit_period = value;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Rounded bit count from the last edge to ts, all modulo 2^32.
    function logic [31:0] run_bits(logic [31:0] ts);
      logic [31:0] p;
      p = (bit_period == 0) ? 32'd1 : bit_period;
      return (ts - last_edge + (p >> 1)) / p;
    endfunction

    function void put_raw(logic [7:0] b);
      etkf_pkg::out_item_t o;
      o.out_byte = b;
      o.last     = 1'b0;
      item_bytes.push_back(o);
    endfunction

    function void put_escaped(logic [7:0] b);
      if (b == etkf_pkg::KISS_FEND) begin
        put_raw(etkf_pkg::KISS_FESC);
        put_raw(etkf_pkg::KISS_TFEND);
      end else if (b == etkf_pkg::KISS_FESC) begin
        put_raw(etkf_pkg::KISS_FESC);
        put_raw(etkf_pkg::KISS_TFESC);
      end else begin
        put_raw(b);
      end
    endfunction

    // Pad and send any partial byte, then the closing FEND.
    function void close_frame();
      if (frame_bits == 0) return;
      if (frame_bits[2:0] != 0) put_escaped(partial);
      put_raw(etkf_pkg::KISS_FEND);
      frame_bits = '0;
      partial    = '0;
    endfunction

    function void append_bit(logic level);
      if (frame_bits == 0) put_raw(etkf_pkg::KISS_FEND);
      if (level) partial[frame_bits[2:0]] = 1'b1;
      frame_bits = frame_bits + 16'd1;
      if (frame_bits[2:0] == 0) begin
        put_escaped(partial);
        partial = '0;
        // Frame full: close it, next bit opens a new one.
        if (frame_bits >= etkf_pkg::MAX_FRAME_BYTES * 8) begin
          put_raw(etkf_pkg::KISS_FEND);
          frame_bits = '0;
        end
      end
    endfunction

    // Called once per input transfer.
    function void note_item(etkf_pkg::in_item_t it);
      logic [31:0] run;
      item_bytes.delete();
      if (it.mode == MODE_FLUSH) begin
        close_frame();
      end else begin
        run = run_bits(it.timestamp);
        if (run != 0) begin
          last_edge = it.timestamp;
          if (run > etkf_pkg::GAP_BITS) close_frame();
          else for (int k = 0; k < run; k++) append_bit(it.timestamp[0]);
        end
      end
      if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
      foreach (item_bytes[i]) expected_q.push_back(item_bytes[i]);
    endfunction

    // Called once per result transfer.
    function void check_result(etkf_pkg::out_item_t got);
      etkf_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: byte with none expected: expected none, actual byte %h last %b",
                 $time, got.out_byte, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %h, actual %h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
      end
    endfunction
  endclass

  // DUT inputs start known; rst held high from time zero.
  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_valid    = 1'b0;
  logic [31:0]         cfg_data     = '0;
  logic                item_valid   = 1'b0;
  etkf_pkg::in_item_t  item         = '0;
  logic                result_ready = 1'b0;
  logic                cfg_ready;
  logic                item_ready;
  logic                result_valid;
  etkf_pkg::out_item_t result;

  kiss_scoreboard sb;

  // Idle knobs: sender gaps are drawn in the stimulus process, receiver stalls below.
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  // Bumping hold_seq asks the receiver for one long hold-off.
  int          hold_seq      = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  int unsigned cycle_count   = 0;

  edge_time_to_kiss_frames_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: random stalls, or a counted hold-off so the block backs up
  // into its input while the sender keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor: ready was set at an earlier edge, so the sampled pair is stable.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // Item builders. run_item and random_item read the predictor's last edge and period,
  // so they are called only after the previous input transfer has been noted.
  function automatic etkf_pkg::in_item_t flush_item(logic [31:0] ts);
    etkf_pkg::in_item_t it;
    it.mode      = MODE_FLUSH;
    it.timestamp = ts;
    return it;
  endfunction

  function automatic etkf_pkg::in_item_t stamp_item(logic [31:0] ts);
    etkf_pkg::in_item_t it;
    it.mode      = MODE_EDGE;
    it.timestamp = ts;
    return it;
  endfunction

  // Edge run bit periods after the last one. Jitter stays inside the rounding
  // window even after bit 0 is forced to the level (needs period >= 4).
  function automatic etkf_pkg::in_item_t run_item(logic [31:0] run, logic level);
    logic [31:0] p;
    logic [31:0] half;
    logic [31:0] ts;
    p    = (sb.bit_period == 0) ? 32'd1 : sb.bit_period;
    half = p >> 1;
    ts   = sb.last_edge + run * p;
    if (half >= 2) ts = ts + $urandom_range(2 * half - 3) - (half - 1);
    ts[0] = level;
    return stamp_item(ts);
  endfunction

  function automatic etkf_pkg::in_item_t random_item();
    int   pick;
    logic lvl;
    pick = $urandom_range(99);
    lvl  = $urandom_range(1);
    if (pick < 7)  return flush_item($urandom);
    if (pick < 11) return stamp_item($urandom);
    if (pick < 16) return run_item($urandom_range(40, 33), lvl);
    if (pick < 19) return run_item(0, lvl);
    // At the largest period only a half-turn step gives a run of one bit.
    if (sb.bit_period == 32'hFFFF_FFFF) return stamp_item(sb.last_edge + 32'h8000_0000);
    if (pick < 30) return run_item($urandom_range(32, 9), lvl);
    return run_item($urandom_range(8, 1), lvl);
  endfunction

  // One input transfer, after a random sender gap. Valid is only lowered
  // when a gap is taken, so back-to-back items keep it high.
  task automatic send_item(etkf_pkg::in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
  endtask

  // Sender pause until every expected byte is out, then let the front end settle.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_period(value);
  endtask

  task automatic set_idle(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 57 : (mode == IDLE_BOTH) ? 6 : 0;
    stall_pct    <= (mode == IDLE_RECEIVER) ? 57 : (mode == IDLE_BOTH) ? 6 : 0;
  endtask

  // Directed items at the reset period: flush and gap with no frame, zero run,
  // escapes of FEND and FESC, the longest run, padded partial bytes, wrap.
  task automatic directed_items();
    send_item(flush_item(32'hFFFF_FFFF));
    send_item(run_item(0, 1'b1));
    send_item(run_item(1, 1'b1));
    send_item(run_item(7, 1'b0));
    // byte 0xc0, LSB first
    send_item(run_item(6, 1'b0));
    send_item(run_item(2, 1'b1));
    // byte 0xdb, LSB first
    send_item(run_item(2, 1'b1));
    send_item(run_item(1, 1'b0));
    send_item(run_item(2, 1'b1));
    send_item(run_item(1, 1'b0));
    send_item(run_item(2, 1'b1));
    send_item(run_item(32, 1'b1));
    // partial byte closed by a gap, then a gap with nothing open
    send_item(run_item(3, 1'b1));
    send_item(run_item(33, 1'b0));
    send_item(run_item(33, 1'b1));
    // partial byte closed by a flush
    send_item(run_item(3, 1'b1));
    send_item(run_item(2, 1'b0));
    send_item(flush_item(32'h0000_0000));
    // jump near the top of the counter, wrap past zero, then far back to zero
    send_item(stamp_item(32'hFFFF_FFF1));
    send_item(run_item(4, 1'b0));
    send_item(stamp_item(32'h0000_0000));
    send_item(flush_item($urandom));
  endtask

  task automatic run_phase(logic [31:0] period, idle_mode_t mode, int count, bit hold_off);
    wait_drained();
    write_period(period);
    set_idle(mode);
    if (hold_off) hold_seq <= hold_seq + 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(49) == 0) wait_drained();
      send_item(random_item());
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    run_phase(32'd1, IDLE_NONE, 50, 1'b0);
    run_phase(32'hFFFF_FFFF, IDLE_BOTH, 30, 1'b0);
    run_phase(32'd1000, IDLE_SENDER, 70, 1'b0);
    run_phase(32'd3, IDLE_RECEIVER, 60, 1'b0);
    run_phase(32'd37, IDLE_NONE, 60, 1'b1);
    run_phase($urandom_range(200000, 4), IDLE_BOTH, 80, 1'b0);
    run_phase(32'd66666, IDLE_RECEIVER, 60, 1'b0);
    wait_drained();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
